@@ hdl/b64d_pkg.sv @@
// Shared types, constants and the character lookup of the Base64 decoder.
package b64d_pkg;

    localparam logic [6:0]  SYM_SKIP  = 7'd64;
    localparam logic [6:0]  SYM_PAD   = 7'd65;
    localparam logic [6:0]  SYM_BAD   = 7'd66;
    localparam logic [7:0]  BYTE_MASK = 8'd255;

    localparam logic [1:0]  STATUS_OK       = 2'd0;
    localparam logic [1:0]  STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0]  STATUS_OVERFLOW = 2'd2;

    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_STATUS = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    // One queue entry: everything that one input word produces.
    typedef struct packed {
        logic [1:0]  n_bytes;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic        has_status;
        logic [1:0]  status;
        logic [15:0] total;
    } t_entry;

    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] v;
        d = 8'd0;
        v = SYM_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            v = d[6:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            v = d[6:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            v = d[6:0];
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else if (c == 8'h0A) begin
            v = SYM_SKIP;
        end else if (c == 8'h3D) begin
            v = SYM_PAD;
        end
        return v;
    endfunction

endpackage

@@ hdl/base64_decoder.sv @@
// A result word is registered first in the entry queue and then in the back end's output register.
// Throughput: one input word per cycle while the entry queue has room; results leave at
// one per cycle while i_stall is low; a word holds the output port until its last result leaves.
// The QUEUE_DEPTH-entry queue between front and back end sets how far input runs ahead.
// Reset (synchronous, active low) clears message state and queue; capacity becomes 1024.
module base64_decoder import b64d_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_char_valid,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_status_code,
    output logic [15:0] o_byte_total,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_output_capacity
);

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry entry;
    t_entry head;

    assign o_stall     = full;
    assign accept      = i_valid && !full;
    assign o_cfg_ready = 1'b1;

    b64d_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_char_code       (i_char_code),
        .i_char_valid      (i_char_valid),
        .i_end_of_text     (i_end_of_text),
        .i_cfg_write       (i_cfg_valid),
        .i_output_capacity (i_output_capacity),
        .o_push            (push),
        .o_entry           (entry)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_data_byte   (o_data_byte),
        .o_status_code (o_status_code),
        .o_byte_total  (o_byte_total),
        .o_last_result (o_last_result)
    );

endmodule

@@ hdl/b64d_front.sv @@
// Front end: accepts text words, tracks message state and builds queue entries.
module b64d_front import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_char_code,
    input  logic        i_char_valid,
    input  logic        i_end_of_text,
    input  logic        i_cfg_write,
    input  logic [15:0] i_output_capacity,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_bw, n_bw;
    logic        r_pad, n_pad;
    logic [1:0]  r_err, n_err;
    logic [15:0] r_cap;

    logic [6:0]  sym;
    logic [23:0] acc_sh;
    logic [16:0] sum_grp;
    logic [16:0] sum_fl;
    logic [1:0]  fl_n;

    assign sym    = sym_value(i_char_code);
    assign acc_sh = {r_acc[17:0], sym[5:0]};

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_bw    = r_bw;
        n_pad   = r_pad;
        n_err   = r_err;
        o_entry = '0;
        sum_grp = {1'b0, r_bw} + 17'd3;
        fl_n    = 2'd0;
        sum_fl  = 17'd0;

        if (i_char_valid && r_err == STATUS_OK && !r_pad) begin
            if (sym == SYM_PAD) begin
                n_pad = 1'b1;
            end else if (sym == SYM_BAD) begin
                n_err = STATUS_BAD_CHAR;
            end else if (sym != SYM_SKIP) begin
                if (r_cnt == 2'd3) begin
                    if (sum_grp > {1'b0, r_cap}) begin
                        n_err = STATUS_OVERFLOW;
                    end else begin
                        o_entry.n_bytes = 2'd3;
                        o_entry.byte0   = acc_sh[23:16];
                        o_entry.byte1   = acc_sh[15:8];
                        o_entry.byte2   = acc_sh[7:0];
                        n_bw            = sum_grp[15:0];
                    end
                    n_acc = 24'd0;
                    n_cnt = 2'd0;
                end else begin
                    n_acc = acc_sh;
                    n_cnt = r_cnt + 2'd1;
                end
            end
        end

        if (i_end_of_text) begin
            // A nonzero count here means no group went out for this word.
            if (n_err == STATUS_OK) begin
                if (n_cnt == 2'd3) begin
                    fl_n          = 2'd2;
                    o_entry.byte0 = n_acc[17:10];
                    o_entry.byte1 = n_acc[9:2];
                end else if (n_cnt == 2'd2) begin
                    fl_n          = 2'd1;
                    o_entry.byte0 = n_acc[11:4];
                end
                sum_fl = {1'b0, n_bw} + {15'd0, fl_n};
                if (fl_n != 2'd0) begin
                    if (sum_fl > {1'b0, r_cap}) begin
                        n_err = STATUS_OVERFLOW;
                    end else begin
                        o_entry.n_bytes = fl_n;
                        n_bw            = sum_fl[15:0];
                    end
                end
            end
            o_entry.has_status = 1'b1;
            o_entry.status     = n_err;
            o_entry.total      = n_bw;
            n_acc = 24'd0;
            n_cnt = 2'd0;
            n_bw  = 16'd0;
            n_pad = 1'b0;
            n_err = STATUS_OK;
        end
    end

    assign o_push = i_accept && (o_entry.n_bytes != 2'd0 || o_entry.has_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 24'd0;
            r_cnt <= 2'd0;
            r_bw  <= 16'd0;
            r_pad <= 1'b0;
            r_err <= STATUS_OK;
            r_cap <= CAPACITY_RESET;
        end else begin
            if (i_accept) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
                r_bw  <= n_bw;
                r_pad <= n_pad;
                r_err <= n_err;
            end
            if (i_cfg_write) begin
                r_cap <= i_output_capacity;
            end
        end
    end

endmodule

@@ hdl/b64d_queue.sv @@
// Small register queue of entries between the front and back ends.
module b64d_queue import b64d_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hdl/b64d_back.sv @@
// Back end: unpacks queue entries into result words, one per cycle while i_stall is low.
module b64d_back import b64d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_head,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic        o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_status_code,
    output logic [15:0] o_byte_total,
    output logic        o_last_result
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_data;
    logic [1:0]  r_status;
    logic [15:0] r_total;
    logic        r_last;

    logic        load;
    logic [2:0]  n_res;
    logic        is_last;
    logic        is_data;
    logic [7:0]  sel_byte;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign n_res   = {1'b0, i_head.n_bytes} + {2'b00, i_head.has_status};
    assign is_last = ({1'b0, r_idx} == n_res - 3'd1);
    assign is_data = (r_idx < i_head.n_bytes);
    assign o_pop   = load && is_last;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.byte0;
            2'd1:    sel_byte = i_head.byte1;
            2'd2:    sel_byte = i_head.byte2;
            default: sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= is_data ? KIND_DATA : KIND_STATUS;
            r_data   <= is_data ? (sel_byte & BYTE_MASK) : 8'd0;
            r_status <= is_data ? STATUS_OK : i_head.status;
            r_total  <= is_data ? 16'd0 : i_head.total;
            r_last   <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_data_byte   = r_data;
    assign o_status_code = r_status;
    assign o_byte_total  = r_total;
    assign o_last_result = r_last;

endmodule
